// ===== hw/rtl/dtg_pkg.sv =====
package dtg_pkg;

	// Signed scratch width for the Q16.16 smoothing arithmetic.
	localparam int SW      = 52;
	// Magnitude width of a saturated multiplier operand (up to 2^47).
	localparam int MAG_W   = 48;
	localparam int PROD_W  = 2 * MAG_W;
	// Divider widths: dividend up to 2^33, divisor up to 2^36 - 1.
	localparam int DIVN_W  = 34;
	localparam int DIVD_W  = 36;
	localparam int CFG_W   = 20;

	typedef logic signed [SW-1:0]  sword_t;
	typedef logic [MAG_W-1:0]      mag_t;
	typedef logic [PROD_W-1:0]     prod_t;
	typedef logic [DIVN_W-1:0]     divn_t;
	typedef logic [DIVD_W-1:0]     divd_t;
	typedef logic [0:0]            reg_idx_t;
	typedef logic [CFG_W-1:0]      cfg_data_t;

	localparam reg_idx_t REG_MAX_VALUE   = 1'b0;
	localparam reg_idx_t REG_SMOOTH_TIME = 1'b1;

	localparam logic [15:0] K_QUAD = 16'd31457;
	localparam logic [15:0] K_CUBE = 16'd15401;
	localparam logic [16:0] Q_ONE  = 17'd65536;
	localparam logic [27:0] MIN_ST = 28'd7;
	localparam logic [23:0] X_MAX  = 24'h80_0000;
	localparam mag_t        SAT_MAG = 48'h8000_0000_0000;
	localparam sword_t      SAT_POS = sword_t'(SAT_MAG);
	localparam sword_t      SAT_NEG = -SAT_POS;

	function automatic sword_t sat47(sword_t a);
		return (a > SAT_POS) ? SAT_POS : ((a < SAT_NEG) ? SAT_NEG : a);
	endfunction

	function automatic mag_t mag_of(sword_t a);
		sword_t t;
		t = a[SW-1] ? -a : a;
		return t[MAG_W-1:0];
	endfunction

endpackage

// ===== hw/rtl/dtg_mul.sv =====
module dtg_mul (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  dtg_pkg::mag_t  a,
	input  dtg_pkg::mag_t  b,
	output logic         done,
	output dtg_pkg::prod_t prod
);
	import dtg_pkg::*;

	// Shift-add multiplier: one multiplier bit per cycle, stops once the
	// remaining multiplier bits are all zero.
	prod_t a_q;
	prod_t acc_q;
	mag_t  b_q;
	logic  busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
		end else if (busy_q && b_q == '0) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= PROD_W'(a);
			b_q   <= b;
			acc_q <= '0;
		end else if (busy_q && b_q != '0) begin
			if (b_q[0]) begin
				acc_q <= acc_q + a_q;
			end
			a_q <= {a_q[PROD_W-2:0], 1'b0};
			b_q <= b_q >> 1;
		end
	end

	assign done = busy_q && (b_q == '0);
	assign prod = acc_q;

endmodule

// ===== hw/rtl/dtg_div.sv =====
module dtg_div (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  dtg_pkg::divn_t  dividend,
	input  dtg_pkg::divd_t  divisor,
	output logic          done,
	output dtg_pkg::divn_t  quot
);
	import dtg_pkg::*;

	localparam int CNT_W = $clog2(DIVN_W + 1);

	// Restoring divider, one quotient bit per cycle. The dividend shifts out
	// of the top of n_q while quotient bits shift in at the bottom.
	divn_t              n_q;
	divd_t              r_q;
	divd_t              d_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               busy_q;
	logic [DIVD_W:0]    trial;
	logic [DIVD_W+1:0]  diff;
	logic               ge;

	assign trial = {r_q, n_q[DIVN_W-1]};
	assign diff  = {1'b0, trial} - {2'b00, d_q};
	assign ge    = !diff[DIVD_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(DIVN_W);
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q <= dividend;
			r_q <= '0;
			d_q <= divisor;
		end else if (busy_q && cnt_q != '0) begin
			r_q <= ge ? diff[DIVD_W-1:0] : trial[DIVD_W-1:0];
			n_q <= {n_q[DIVN_W-2:0], ge};
		end
	end

	assign done = busy_q && (cnt_q == '0);
	assign quot = n_q;

endmodule

// ===== hw/rtl/damped_trailing_gauge.sv =====
// A set item at or above max_value needs no arithmetic and a set item below it takes one
// division; a tick with nonzero elapsed_time and smooth_time takes two divisions and ten
// multiplications, on the serial divider and the shift-add multiplier.
// One item is worked on at a time.
// Reset (arst_n low, asynchronous) clears the levels and the velocity, loads max_value 100
// and smooth_time 16384, and empties the output register.
module damped_trailing_gauge #(
	parameter int TIME_FRAC_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr_en,
	input  dtg_pkg::reg_idx_t   wr_index,
	input  dtg_pkg::cfg_data_t  wr_data,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                func,
	input  logic [15:0]         raw_level,
	input  logic [15:0]         elapsed_time,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [15:0]         gauge_level,
	output logic [15:0]         trailing_level
);
	import dtg_pkg::*;

	// Times are brought to 16 fraction bits by a right or a left shift.
	localparam int SHR = (TIME_FRAC_BITS >= 16) ? TIME_FRAC_BITS - 16 : 0;
	localparam int SHL = (TIME_FRAC_BITS < 16) ? 16 - TIME_FRAC_BITS : 0;

	// Sequencer states. Each arithmetic state starts its unit once and waits
	// for it to finish before it moves on.
	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_LVL   = 4'd1;
	localparam logic [3:0] S_OMEGA = 4'd2;
	localparam logic [3:0] S_X     = 4'd3;
	localparam logic [3:0] S_X2    = 4'd4;
	localparam logic [3:0] S_X3    = 4'd5;
	localparam logic [3:0] S_KQ    = 4'd6;
	localparam logic [3:0] S_KC    = 4'd7;
	localparam logic [3:0] S_EX    = 4'd8;
	localparam logic [3:0] S_P1    = 4'd9;
	localparam logic [3:0] S_TEMP  = 4'd10;
	localparam logic [3:0] S_P2    = 4'd11;
	localparam logic [3:0] S_VN    = 4'd12;
	localparam logic [3:0] S_P3    = 4'd13;
	localparam logic [3:0] S_FIN   = 4'd14;
	localparam logic [3:0] S_EMIT  = 4'd15;

	logic [3:0]          state_q;
	logic                issued_q;
	logic                out_valid_q;
	logic [15:0]         gauge_q;
	logic [15:0]         trail_out_q;

	// Configuration and architectural state.
	logic [15:0]         max_value_q;
	logic [19:0]         smooth_time_q;
	logic [15:0]         level_now_q;
	logic [15:0]         level_trail_q;
	logic signed [31:0]  vel_q;

	// Working registers of one tick.
	logic [15:0]         raw_q;
	logic [27:0]         st_q;
	logic [23:0]         dt_q;
	logic [30:0]         omega_q;
	logic [23:0]         x_q;
	logic [30:0]         x2_q;
	logic [37:0]         x3_q;
	logic [28:0]         kq_q;
	logic [35:0]         den_q;
	logic [16:0]         ex_q;
	logic signed [31:0]  change_q;
	logic signed [31:0]  tprime_q;
	sword_t              temp_q;
	sword_t              p_q;
	sword_t              vn_q;
	logic                neg_q;

	logic                in_acc;
	logic [15:0]         mv;
	logic [27:0]         st_conv;
	logic [27:0]         st_min;
	logic [23:0]         dt_conv;

	logic                is_mul;
	logic                is_div;
	logic                mul_start;
	logic                div_start;
	logic                mul_done;
	logic                div_done;
	logic                mul_fin;
	logic                div_fin;
	prod_t               mul_prod;
	divn_t               div_quot;
	sword_t              opa;
	sword_t              opb;
	sword_t              sa;
	sword_t              sb;
	divn_t               div_n;
	divd_t               div_d;
	logic [79:0]         m_full;
	mag_t                m_sat;
	sword_t              mul_res;
	logic [23:0]         x_c;

	logic signed [31:0]  cur;
	logic signed [31:0]  tgt;
	logic signed [31:0]  diff_c;
	logic signed [31:0]  maxc;
	logic signed [31:0]  change_c;
	sword_t              out_c;
	logic                snap;
	sword_t              out_g;
	sword_t              v_g;
	logic signed [31:0]  v_sat;
	logic [16:0]         out_clamp;
	logic [17:0]         out_rnd;
	logic                emit_load;

	assign in_acc    = in_valid && !in_stall;
	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign gauge_level    = gauge_q;
	assign trailing_level = trail_out_q;
	assign emit_load = (state_q == S_EMIT) && (!out_valid_q || !out_stall);

	// A max_value of zero acts as one.
	assign mv      = (max_value_q == '0) ? 16'd1 : max_value_q;
	assign st_conv = 28'(({8'b0, smooth_time_q} >> SHR) << SHL);
	assign st_min  = (st_conv < MIN_ST) ? MIN_ST : st_conv;
	assign dt_conv = 24'(({8'b0, elapsed_time} >> SHR) << SHL);

	assign is_mul = (state_q == S_X) || (state_q == S_X2) || (state_q == S_X3) ||
		(state_q == S_KQ) || (state_q == S_KC) || (state_q == S_P1) ||
		(state_q == S_TEMP) || (state_q == S_P2) || (state_q == S_VN) ||
		(state_q == S_P3);
	assign is_div = (state_q == S_LVL) || (state_q == S_OMEGA) || (state_q == S_EX);
	assign mul_start = is_mul && !issued_q;
	assign div_start = is_div && !issued_q;
	assign mul_fin   = issued_q && mul_done;
	assign div_fin   = issued_q && div_done;

	// Multiplier operands. Every product goes through the same signed,
	// saturating Q16.16 path; the unsigned ones are well inside its range.
	always_comb begin
		opa = '0;
		opb = '0;
		case (state_q)
			S_X: begin
				opa = sword_t'(omega_q);
				opb = sword_t'(dt_q);
			end
			S_X2: begin
				opa = sword_t'(x_q);
				opb = sword_t'(x_q);
			end
			S_X3: begin
				opa = sword_t'(x2_q);
				opb = sword_t'(x_q);
			end
			S_KQ: begin
				opa = sword_t'(x2_q);
				opb = sword_t'(K_QUAD);
			end
			S_KC: begin
				opa = sword_t'(x3_q);
				opb = sword_t'(K_CUBE);
			end
			S_P1: begin
				opa = sword_t'(omega_q);
				opb = sword_t'(change_q);
			end
			S_TEMP: begin
				opa = sword_t'(vel_q) + p_q;
				opb = sword_t'(dt_q);
			end
			S_P2: begin
				opa = temp_q;
				opb = sword_t'(omega_q);
			end
			S_VN: begin
				opa = sword_t'(vel_q) - p_q;
				opb = sword_t'(ex_q);
			end
			S_P3: begin
				opa = sword_t'(change_q) + temp_q;
				opb = sword_t'(ex_q);
			end
			default: begin
				opa = '0;
				opb = '0;
			end
		endcase
	end

	assign sa = sat47(opa);
	assign sb = sat47(opb);

	// The product magnitude is truncated by 16 bits and capped at 2^47.
	assign m_full  = mul_prod[PROD_W-1:16];
	assign m_sat   = (m_full > 80'(SAT_MAG)) ? SAT_MAG : m_full[MAG_W-1:0];
	assign mul_res = neg_q ? -sword_t'(m_sat) : sword_t'(m_sat);
	assign x_c     = (mul_res > sword_t'(X_MAX)) ? X_MAX : mul_res[23:0];

	// Divider operands: the gauge quotient, omega and the exponential factor.
	always_comb begin
		div_n = '0;
		div_d = '0;
		case (state_q)
			S_LVL: begin
				div_n = divn_t'({raw_q, 15'b0});
				div_d = divd_t'(mv);
			end
			S_OMEGA: begin
				div_n = divn_t'(1) << 33;
				div_d = divd_t'(st_q);
			end
			S_EX: begin
				div_n = divn_t'(1) << 32;
				div_d = den_q;
			end
			default: begin
				div_n = '0;
				div_d = '0;
			end
		endcase
	end

	// Levels are Q1.15 and become Q16.16 by a left shift of one.
	assign cur    = $signed({15'b0, level_trail_q, 1'b0});
	assign tgt    = $signed({15'b0, level_now_q, 1'b0});
	assign diff_c = cur - tgt;
	assign maxc   = $signed({3'b0, st_q, 1'b0});

	always_comb begin
		if (diff_c > maxc) begin
			change_c = maxc;
		end else if (diff_c < -maxc) begin
			change_c = -maxc;
		end else begin
			change_c = diff_c;
		end
	end

	// The overshoot guard snaps to the target when the new level lies on the
	// far side of it, or when the target did not lie above the old level and
	// the new level does not lie above the target.
	assign out_c = sword_t'(tprime_q) + p_q;
	assign snap  = ((tgt - cur) > 0) == (out_c > sword_t'(tgt));
	assign out_g = snap ? sword_t'(tgt) : out_c;
	assign v_g   = snap ? '0 : vn_q;

	always_comb begin
		if (v_g > sword_t'(32'sh7FFF_FFFF)) begin
			v_sat = 32'sh7FFF_FFFF;
		end else if (v_g < sword_t'(-33'sh8000_0000)) begin
			v_sat = -32'sh8000_0000;
		end else begin
			v_sat = v_g[31:0];
		end
	end

	always_comb begin
		if (out_g < 0) begin
			out_clamp = '0;
		end else if (out_g > sword_t'(Q_ONE)) begin
			out_clamp = Q_ONE;
		end else begin
			out_clamp = out_g[16:0];
		end
	end

	// Round half up into Q1.15; the clamp already keeps this at or below one.
	assign out_rnd = ({1'b0, out_clamp} + 18'd1) >> 1;

	dtg_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mag_of(sa)),
		.b      (mag_of(sb)),
		.done   (mul_done),
		.prod   (mul_prod)
	);

	dtg_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_n),
		.divisor  (div_d),
		.done     (div_done),
		.quot     (div_quot)
	);

	// Control, configuration and the gauge state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			issued_q      <= 1'b0;
			out_valid_q   <= 1'b0;
			max_value_q   <= 16'd100;
			smooth_time_q <= 20'd16384;
			level_now_q   <= '0;
			level_trail_q <= '0;
			vel_q         <= '0;
		end else begin
			if (wr_en) begin
				case (wr_index)
					REG_MAX_VALUE:   max_value_q   <= wr_data[15:0];
					REG_SMOOTH_TIME: smooth_time_q <= wr_data;
					default: ;
				endcase
			end
			if (mul_start || div_start) begin
				issued_q <= 1'b1;
			end
			if (mul_fin || div_fin) begin
				issued_q <= 1'b0;
			end
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						if (!func) begin
							if (raw_level >= mv) begin
								level_now_q <= 16'd32768;
								state_q     <= S_EMIT;
							end else begin
								state_q <= S_LVL;
							end
						end else if (elapsed_time == '0) begin
							state_q <= S_EMIT;
						end else if (smooth_time_q == '0) begin
							level_trail_q <= level_now_q;
							vel_q         <= '0;
							state_q       <= S_EMIT;
						end else begin
							state_q <= S_OMEGA;
						end
					end
				end
				S_LVL: begin
					if (div_fin) begin
						level_now_q <= div_quot[15:0];
						state_q     <= S_EMIT;
					end
				end
				S_OMEGA: if (div_fin) state_q <= S_X;
				S_X:     if (mul_fin) state_q <= S_X2;
				S_X2:    if (mul_fin) state_q <= S_X3;
				S_X3:    if (mul_fin) state_q <= S_KQ;
				S_KQ:    if (mul_fin) state_q <= S_KC;
				S_KC:    if (mul_fin) state_q <= S_EX;
				S_EX:    if (div_fin) state_q <= S_P1;
				S_P1:    if (mul_fin) state_q <= S_TEMP;
				S_TEMP:  if (mul_fin) state_q <= S_P2;
				S_P2:    if (mul_fin) state_q <= S_VN;
				S_VN:    if (mul_fin) state_q <= S_P3;
				S_P3:    if (mul_fin) state_q <= S_FIN;
				S_FIN: begin
					vel_q         <= v_sat;
					level_trail_q <= out_rnd[15:0];
					state_q       <= S_EMIT;
				end
				S_EMIT: begin
					if (emit_load) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Working registers and the output word.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			raw_q <= raw_level;
			st_q  <= st_min;
			dt_q  <= dt_conv;
		end
		if (mul_start) begin
			neg_q <= sa[SW-1] ^ sb[SW-1];
		end
		if (mul_fin) begin
			case (state_q)
				S_X:    x_q    <= x_c;
				S_X2:   x2_q   <= mul_res[30:0];
				S_X3:   x3_q   <= mul_res[37:0];
				S_KQ:   kq_q   <= mul_res[28:0];
				S_KC:   den_q  <= 36'(Q_ONE) + 36'(x_q) + 36'(kq_q) + 36'(mul_res[34:0]);
				S_TEMP: temp_q <= mul_res;
				S_VN:   vn_q   <= mul_res;
				S_P1, S_P2, S_P3: p_q <= mul_res;
				default: ;
			endcase
		end
		if (div_fin) begin
			case (state_q)
				S_OMEGA: omega_q <= div_quot[30:0];
				S_EX: begin
					ex_q     <= div_quot[16:0];
					change_q <= change_c;
					tprime_q <= cur - change_c;
				end
				default: ;
			endcase
		end
		if (emit_load) begin
			gauge_q     <= level_now_q;
			trail_out_q <= level_trail_q;
		end
	end

	a_units_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(mul_done && div_done))
		else $error("multiplier and divider finished together");

	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> (state_q != S_IDLE))
		else $error("accepted word did not start work");

	a_emit_fills_output: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT && !out_stall) |=> out_valid_q)
		else $error("result word not presented");

	a_gauge_range: assert property (@(posedge clk) disable iff (!arst_n)
		level_now_q <= 16'd32768)
		else $error("gauge level above full scale");

	a_trail_range: assert property (@(posedge clk) disable iff (!arst_n)
		level_trail_q <= 16'd32768)
		else $error("trailing level above full scale");

endmodule

// ===== verif/dtg_checker.sv =====
`timescale 1ns / 1ps

// Watches both channels of the gauge, keeps its own copy of the smoothing
// state, and compares every output word with the oldest expected one.
module dtg_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr_en,
	input  dtg_pkg::reg_idx_t  wr_index,
	input  dtg_pkg::cfg_data_t wr_data,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic               func,
	input  logic [15:0]        raw_level,
	input  logic [15:0]        elapsed_time,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic [15:0]        gauge_level,
	input  logic [15:0]        trailing_level,
	output int                 fail_count,
	output int                 pending
);
	import dtg_pkg::*;

	typedef struct packed {
		logic [15:0] gauge;
		logic [15:0] trail;
	} levels_t;

	localparam longint LIM = 64'sd1 << 47;

	logic [15:0] cfg_max;
	logic [19:0] cfg_st;
	logic [15:0] lvl_now;
	logic [15:0] lvl_trail;
	longint      vel;
	levels_t     expected_levels[$];

	function automatic longint clip47(longint a);
		return (a > LIM) ? LIM : ((a < -LIM) ? -LIM : a);
	endfunction

	// Signed fixed-point product, truncated toward zero and saturated.
	function automatic longint fx_mul(longint a, longint b);
		longint ua, ub;
		logic [127:0] m;
		logic neg;
		a = clip47(a);
		b = clip47(b);
		neg = (a < 0) != (b < 0);
		ua = (a < 0) ? -a : a;
		ub = (b < 0) ? -b : b;
		m = (128'(ua) * 128'(ub)) >> 16;
		if (m > 128'(LIM))
			m = 128'(LIM);
		return neg ? -longint'(m) : longint'(m);
	endfunction

	// One critically damped step of the trailing level toward the gauge.
	task automatic advance_trail(input logic [15:0] dt_raw);
		longint dt, st, omega, x, x2, x3, den, ex, cur, tgt, change, maxc, tp, tmp, v, o;
		if (dt_raw == 0)
			return;
		if (cfg_st == 0) begin
			lvl_trail = lvl_now;
			vel = 0;
			return;
		end
		dt = dt_raw;
		st = cfg_st;
		if (st < 7)
			st = 7;
		omega = (64'sd2 << 32) / st;
		x = (omega * dt) / 65536;
		if (x > (64'sd1 << 23))
			x = 64'sd1 << 23;
		x2 = (x * x) / 65536;
		x3 = (x2 * x) / 65536;
		den = 65536 + x + (31457 * x2) / 65536 + (15401 * x3) / 65536;
		ex = (64'sd1 << 32) / den;
		v = vel;
		cur = 2 * longint'(lvl_trail);
		tgt = 2 * longint'(lvl_now);
		change = cur - tgt;
		maxc = 2 * st;
		if (change > maxc)
			change = maxc;
		if (change < -maxc)
			change = -maxc;
		tp = cur - change;
		tmp = fx_mul(v + fx_mul(omega, change), dt);
		v = fx_mul(v - fx_mul(omega, tmp), ex);
		o = tp + fx_mul(change + tmp, ex);
		// Overshoot guard: land exactly on the target with no velocity.
		if ((tgt - cur > 0) == (o > tgt)) begin
			o = tgt;
			v = 0;
		end
		if (v > 64'sd2147483647)
			v = 64'sd2147483647;
		if (v < -64'sd2147483648)
			v = -64'sd2147483648;
		vel = v;
		if (o < 0)
			o = 0;
		if (o > 65536)
			o = 65536;
		o = (o + 1) / 2;
		if (o > 32768)
			o = 32768;
		lvl_trail = 16'(o);
	endtask

	always @(posedge clk or negedge arst_n) begin
		levels_t e;
		logic [31:0] mv;
		if (!arst_n) begin
			cfg_max <= 16'd100;
			cfg_st <= 20'd16384;
			lvl_now = 0;
			lvl_trail = 0;
			vel = 0;
			expected_levels.delete();
			fail_count <= 0;
		end else begin
			if (wr_en) begin
				if (wr_index == REG_MAX_VALUE)
					cfg_max <= wr_data[15:0];
				else
					cfg_st <= wr_data;
			end
			if (out_valid && !out_stall) begin
				if (expected_levels.size() == 0) begin
					fail_count <= fail_count + 1;
					if (fail_count < 10)
						$display("unexpected word: gauge %0d trail %0d",
							gauge_level, trailing_level);
				end else begin
					e = expected_levels.pop_front();
					if (e.gauge !== gauge_level || e.trail !== trailing_level) begin
						fail_count <= fail_count + 1;
						if (fail_count < 10)
							$display("mismatch: expected gauge %0d trail %0d, got %0d %0d",
								e.gauge, e.trail, gauge_level, trailing_level);
					end
				end
			end
			if (in_valid && !in_stall) begin
				if (func == 1'b0) begin
					mv = (cfg_max == 0) ? 1 : cfg_max;
					if (raw_level >= mv)
						lvl_now = 16'd32768;
					else
						lvl_now = 16'((32'(raw_level) << 15) / mv);
				end else begin
					advance_trail(elapsed_time);
				end
				expected_levels.push_back('{gauge: lvl_now, trail: lvl_trail});
			end
		end
		pending <= expected_levels.size();
	end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps

// Top of the gauge testbench. It drives words and register writes, shapes
// the stall on the output side, and gives the verdict from the checker.
module tb;
	import dtg_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        wr_en;
	reg_idx_t    wr_index;
	cfg_data_t   wr_data;
	logic        in_valid;
	logic        in_stall;
	logic        func;
	logic [15:0] raw_level;
	logic [15:0] elapsed_time;
	logic        out_valid;
	logic        out_stall;
	logic [15:0] gauge_level;
	logic [15:0] trailing_level;
	int          fail_count;
	int          pending;
	int          idle_cycles;
	// When set, the receiver holds off once for a long fixed stretch.
	logic        hold_request;

	damped_trailing_gauge uut (.*);

	dtg_checker checker_i (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// Mostly short gaps, now and then a long one.
	function automatic int gap_len();
		int r;
		r = $urandom_range(99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(3, 1);
		return $urandom_range(80, 10);
	endfunction

	// The output side stalls at random, and once holds off for a long
	// stretch so that the block backs up and stalls its input.
	initial begin
		int n;
		bit held;
		held = 1'b0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request && !held) begin
				out_stall <= 1'b1;
				repeat (3000) @(negedge clk);
				out_stall <= 1'b0;
				held = 1'b1;
			end else if ($urandom_range(3) == 0) begin
				n = gap_len();
				if (n > 0) begin
					out_stall <= 1'b1;
					repeat (n - 1) @(negedge clk);
				end
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// Drive one word and wait until the block takes it. The block is busy
	// after taking a word, so the idle cycle after the drop of valid costs
	// no throughput.
	task automatic send_word(input logic f, input logic [15:0] raw, input logic [15:0] dt);
		in_valid <= 1'b1;
		func <= f;
		raw_level <= raw;
		elapsed_time <= dt;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		@(negedge clk);
		in_valid <= 1'b0;
		repeat (gap_len() + 1) @(negedge clk);
	endtask

	// Register writes happen only when the block has drained; a tick can
	// still be finishing after its word arrived, so wait out its latency.
	task automatic write_reg(input reg_idx_t idx, input cfg_data_t val);
		while (pending != 0)
			@(negedge clk);
		repeat (700) @(negedge clk);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= val;
		@(negedge clk);
		wr_en <= 1'b0;
	endtask

	// Random elapsed time, weighted toward short ticks and the edges.
	function automatic logic [15:0] rand_dt();
		case ($urandom_range(9))
			0: return 16'd0;
			1: return 16'hFFFF;
			2, 3: return 16'($urandom_range(65535));
			default: return 16'($urandom_range(2000, 1));
		endcase
	endfunction

	// A phase: a random mix of set words and ticks, some set words with small raw levels.
	task automatic run_phase(input int words);
		int k;
		k = 0;
		while (k < words) begin
			if ($urandom_range(3) == 0)
				send_word(1'b0, 16'($urandom_range(65535)), 16'($urandom_range(65535)));
			else if ($urandom_range(2) == 0)
				send_word(1'b0, 16'($urandom_range(200)), 16'($urandom));
			else
				send_word(1'b1, 16'($urandom), rand_dt());
			k++;
		end
	endtask

	// Ends the run if nothing moves across either channel for too long.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 20000) begin
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		int p;
		arst_n = 1'b0;
		wr_en = 1'b0;
		wr_index = REG_MAX_VALUE;
		wr_data = '0;
		in_valid = 1'b0;
		func = 1'b0;
		raw_level = '0;
		elapsed_time = '0;
		hold_request = 1'b0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed part with the reset settings: edges of the raw level,
		// a zero tick, long and short ticks, and a drop back to zero.
		send_word(1'b1, 16'd0, 16'd1000);
		send_word(1'b0, 16'd0, 16'd0);
		send_word(1'b0, 16'd99, 16'd0);
		send_word(1'b0, 16'd100, 16'd0);
		send_word(1'b0, 16'hFFFF, 16'hFFFF);
		send_word(1'b1, 16'hFFFF, 16'd0);
		send_word(1'b1, 16'd0, 16'd1);
		send_word(1'b1, 16'd0, 16'd1000);
		send_word(1'b1, 16'd0, 16'hFFFF);
		send_word(1'b0, 16'd0, 16'd0);
		send_word(1'b1, 16'd0, 16'd500);
		send_word(1'b1, 16'd0, 16'hFFFF);
		send_word(1'b0, 16'd50, 16'd0);
		send_word(1'b1, 16'd0, 16'd2000);

		// Smooth time zero snaps; the tiny value exercises the lower bound.
		write_reg(REG_SMOOTH_TIME, 20'd0);
		send_word(1'b0, 16'd25, 16'd0);
		send_word(1'b1, 16'd0, 16'd0);
		send_word(1'b1, 16'd0, 16'd3);
		write_reg(REG_SMOOTH_TIME, 20'd1);
		send_word(1'b0, 16'd100, 16'd0);
		send_word(1'b1, 16'd0, 16'd1);
		send_word(1'b1, 16'd0, 16'hFFFF);
		write_reg(REG_MAX_VALUE, 20'd0);
		send_word(1'b0, 16'd0, 16'd0);
		send_word(1'b0, 16'd1, 16'd0);
		write_reg(REG_MAX_VALUE, 20'hFFFF);
		send_word(1'b0, 16'hFFFE, 16'd0);
		write_reg(REG_SMOOTH_TIME, 20'hFFFFF);
		send_word(1'b1, 16'd0, 16'hFFFF);

		// Random phases across a spread of settings, extremes included.
		for (p = 0; p < 12; p++) begin
			write_reg(REG_MAX_VALUE, (p % 4 == 0) ? 20'd1 :
				(p % 4 == 1) ? 20'hFFFF : 20'($urandom_range(300, 1)));
			case (p % 5)
				0: write_reg(REG_SMOOTH_TIME, 20'd0);
				1: write_reg(REG_SMOOTH_TIME, 20'hFFFFF);
				2: write_reg(REG_SMOOTH_TIME, 20'($urandom_range(8)));
				default: write_reg(REG_SMOOTH_TIME, 20'($urandom_range(100000, 1000)));
			endcase
			if (p == 3) begin
				// Long receiver hold while words keep coming in.
				hold_request = 1'b1;
				run_phase(40);
			end else begin
				run_phase(150);
			end
			if (p == 6) begin
				// The sender pauses until the block has fully drained.
				while (pending != 0)
					@(negedge clk);
			end
		end

		while (pending != 0)
			@(negedge clk);
		repeat (700) @(negedge clk);
		if (fail_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

// ===== files.f =====
hw/rtl/dtg_pkg.sv
hw/rtl/dtg_mul.sv
hw/rtl/dtg_div.sv
hw/rtl/damped_trailing_gauge.sv
verif/dtg_checker.sv
verif/tb.sv
